>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
// Needs clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold whenever the antecedent does
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> rtl/tsc_pkg.sv
// Package for the Taylor sine/cosine evaluator: constants, state and command types.
// No dependencies.
`default_nettype none
package tsc_pkg;

  localparam int MAX_TERMS   = 10;
  localparam int FRAC_BITS   = 24;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 4;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TWO_PI_Q64 =
    (TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);

  // reduced magnitude is at most 2*pi, below 2^(FRAC_BITS+3)
  localparam int AX_W        = FRAC_BITS + 3;
  localparam logic [AX_W-1:0] TWO_PI_Q = TWO_PI_Q64[AX_W-1:0];
  // quotient bits of the range reduction
  localparam int QB          = 29 - FRAC_BITS;

  localparam int MAG_W       = 31;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam int PROD_W      = MAG_W + AX_W;
  localparam int DIVD_W      = PROD_W - FRAC_BITS;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CYC     = (DIVD_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DQ_W        = DIV_CYC * DIV_STEPS;
  localparam int K_W         = $clog2(2 * MAX_TERMS);
  localparam int REM_W       = K_W + 1;
  localparam int CNT_MAX     = (QB > DIV_CYC) ? QB : DIV_CYC;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_DIFF
  } tsc_state_t;

  typedef struct packed {
    logic           load;
    logic           red;
    logic           mul;
    logic           div;
    logic           acc;
    logic           diff;
    logic [K_W-1:0] k;
  } tsc_cmd_t;

endpackage
`default_nettype wire

>>> rtl/tsc_ctrl.sv
// Controller of the Taylor sine/cosine evaluator: sequencer, term counter,
// term_count register and result valid. Depends on tsc_pkg.
`default_nettype none
module tsc_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_wr_en,
  input  wire  [tsc_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire                         in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire                         out_stall,
  output tsc_pkg::tsc_cmd_t           cmd
);
  import tsc_pkg::*;

  tsc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   kmax_r, kmax_nxt;
  logic [CFG_W-1:0] term_count_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] t_clamp;
  logic [K_W:0]     t_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      k_r          <= '0;
      kmax_r       <= '0;
      term_count_r <= CFG_W'(MAX_TERMS);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      kmax_r      <= kmax_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        term_count_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    if (term_count_r == '0) begin
      t_clamp = CFG_W'(1);
    end else if (term_count_r > CFG_W'(MAX_TERMS)) begin
      t_clamp = CFG_W'(MAX_TERMS);
    end else begin
      t_clamp = term_count_r;
    end
    t_ext = (K_W+1)'(t_clamp);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    kmax_nxt      = kmax_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.k         = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          k_nxt     = K_W'(1);
          kmax_nxt  = K_W'((t_ext << 1) - 1'b1);
          cnt_nxt   = CNT_W'(QB - 1);
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        cmd.red = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = CNT_W'(DIV_CYC - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_ACC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (k_r == kmax_r) begin
          state_nxt = ST_DIFF;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DIFF: begin
        if (!out_valid_r || !out_stall) begin
          cmd.diff      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/tsc_dp.sv
// Datapath of the Taylor sine/cosine evaluator: range reduction, shared
// multiplier, small divider, saturating accumulators. Depends on tsc_pkg.
`default_nettype none
module tsc_dp (
  input  wire                                clk,
  input  tsc_pkg::tsc_cmd_t                  cmd,
  input  wire  signed [tsc_pkg::DATA_W-1:0]  in_angle,
  output logic signed [tsc_pkg::DATA_W-1:0]  out_sine_value,
  output logic signed [tsc_pkg::DATA_W-1:0]  out_cosine_value,
  output logic signed [tsc_pkg::DATA_W-1:0]  out_sine_minus_cosine,
  output logic                               out_saturated_flag
);
  import tsc_pkg::*;

  logic                     xneg_r;
  logic                     red_do_r;
  logic [DATA_W-1:0]        ax_r;
  logic [DATA_W-1:0]        tq_r;
  logic [MAG_W-1:0]         mag_r;
  logic [DQ_W-1:0]          dq_r;
  logic [REM_W-1:0]         rem_r;
  logic signed [DATA_W-1:0] sine_r;
  logic signed [DATA_W-1:0] cos_r;
  logic                     flag_r;
  logic signed [DATA_W-1:0] o_sine_r, o_cos_r, o_diff_r;
  logic                     o_flag_r;

  logic [DATA_W-1:0]        ax_in;
  logic [PROD_W-1:0]        prod;
  logic [DQ_W-1:0]          dq_nxt;
  logic [REM_W-1:0]         rem_nxt;
  logic                     mag_clip;
  logic [MAG_W-1:0]         mag_c;
  logic                     neg;
  logic signed [DATA_W+1:0] acc_sum;
  logic [DATA_W:0]          acc_sat;
  logic signed [DATA_W+1:0] diff_full;
  logic [DATA_W:0]          diff_sat;

  function automatic logic [DATA_W:0] sat32(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W+1:0] hi;
    logic signed [DATA_W+1:0] lo;
    hi = (DATA_W+2)'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - (DATA_W+2)'(1);
    if (v > hi) begin
      sat32 = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, v[DATA_W-1:0]};
    end
  endfunction

  assign ax_in = in_angle[DATA_W-1] ? (~in_angle + 1'b1) : in_angle;
  assign prod  = PROD_W'(mag_r) * PROD_W'(ax_r[AX_W-1:0]);

  // restoring division by k, DIV_STEPS quotient bits a cycle
  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_nxt = {rem_nxt[REM_W-2:0], dq_nxt[DQ_W-1]};
      dq_nxt  = {dq_nxt[DQ_W-2:0], 1'b0};
      if (rem_nxt >= REM_W'(cmd.k)) begin
        rem_nxt   = rem_nxt - REM_W'(cmd.k);
        dq_nxt[0] = 1'b1;
      end
    end
  end

  always_comb begin
    mag_clip = (dq_r > DQ_W'(MAG_MAX));
    mag_c    = mag_clip ? MAG_MAX : dq_r[MAG_W-1:0];
    neg      = (xneg_r & cmd.k[0]) ^ cmd.k[1];
    if (neg) begin
      acc_sum = (cmd.k[0] ? (DATA_W+2)'(sine_r) : (DATA_W+2)'(cos_r))
                - (DATA_W+2)'(mag_c);
    end else begin
      acc_sum = (cmd.k[0] ? (DATA_W+2)'(sine_r) : (DATA_W+2)'(cos_r))
                + (DATA_W+2)'(mag_c);
    end
    acc_sat   = sat32(acc_sum);
    diff_full = (DATA_W+2)'(sine_r) - (DATA_W+2)'(cos_r);
    diff_sat  = sat32(diff_full);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xneg_r   <= in_angle[DATA_W-1];
      ax_r     <= ax_in;
      red_do_r <= (ax_in > DATA_W'(TWO_PI_Q));
      tq_r     <= DATA_W'(TWO_PI_Q) << (QB - 1);
      mag_r    <= MAG_W'(1) << FRAC_BITS;
      sine_r   <= '0;
      cos_r    <= DATA_W'(1) << FRAC_BITS;
      flag_r   <= 1'b0;
    end
    if (cmd.red) begin
      if (red_do_r && (ax_r >= tq_r)) begin
        ax_r <= ax_r - tq_r;
      end
      tq_r <= tq_r >> 1;
    end
    if (cmd.mul) begin
      dq_r  <= DQ_W'(prod[PROD_W-1:FRAC_BITS]);
      rem_r <= '0;
    end
    if (cmd.div) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.acc) begin
      mag_r <= mag_c;
      if (cmd.k[0]) begin
        sine_r <= acc_sat[DATA_W-1:0];
      end else begin
        cos_r <= acc_sat[DATA_W-1:0];
      end
      flag_r <= flag_r | mag_clip | acc_sat[DATA_W];
    end
    if (cmd.diff) begin
      o_sine_r <= sine_r;
      o_cos_r  <= cos_r;
      o_diff_r <= diff_sat[DATA_W-1:0];
      o_flag_r <= flag_r | diff_sat[DATA_W];
    end
  end

  assign out_sine_value        = o_sine_r;
  assign out_cosine_value      = o_cos_r;
  assign out_sine_minus_cosine = o_diff_r;
  assign out_saturated_flag    = o_flag_r;

endmodule
`default_nettype wire

>>> rtl/taylor_sin_cos_evaluator.sv
// Taylor-series sine/cosine evaluator, top level. One angle (signed Q8.24) in,
// one result out: sine, cosine, sine minus cosine, clip flag. An item runs
// range reduction first, then per series term (2*T-1 of them for T terms) a
// step on the shared multiplier, a division by k on the 8-bit-per-cycle
// divider and an accumulate, and last moves into the output register.
// A new angle is taken once the previous one has moved into the output register.
// Depends on tsc_pkg, tsc_ctrl, tsc_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module taylor_sin_cos_evaluator (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [tsc_pkg::CFG_W-1:0]          cfg_wr_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  signed [tsc_pkg::DATA_W-1:0]  in_angle,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [tsc_pkg::DATA_W-1:0]  out_sine_value,
  output logic signed [tsc_pkg::DATA_W-1:0]  out_cosine_value,
  output logic signed [tsc_pkg::DATA_W-1:0]  out_sine_minus_cosine,
  output logic                               out_saturated_flag
);
  import tsc_pkg::*;

  tsc_cmd_t cmd;

  tsc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  tsc_dp u_dp (
    .clk                   (clk),
    .cmd                   (cmd),
    .in_angle              (in_angle),
    .out_sine_value        (out_sine_value),
    .out_cosine_value      (out_cosine_value),
    .out_sine_minus_cosine (out_sine_minus_cosine),
    .out_saturated_flag    (out_saturated_flag)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat not held busy")
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.red, cmd.mul, cmd.div, cmd.acc, cmd.diff}), "overlapping commands")
  `ASSERT_IMP(a_diff_exact, out_valid && !out_saturated_flag, (out_sine_value - out_cosine_value) == out_sine_minus_cosine, "difference wrong without clip")

endmodule
`default_nettype wire

>>> sim/taylor_sin_cos_evaluator_tb.sv
// Testbench for the Taylor sine/cosine evaluator: directed and random angles
// over several term counts, each result checked against an in-bench predictor.
// Depends on tsc_pkg and the taylor_sin_cos_evaluator RTL.
`default_nettype none
module taylor_sin_cos_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1900;
  localparam int WDOG_LIMIT = 20000;
  localparam int QUIET_TAIL = 400;

  typedef struct {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
    logic signed [31:0] diff;
    logic               sat;
  } trig_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [tsc_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_sine_value, out_cosine_value, out_sine_minus_cosine;
  logic out_saturated_flag;

  logic signed [31:0] angle_q[$];
  trig_t              trig_q[$];
  logic [3:0]         terms_cur = 4'd10;
  int  mismatches = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  timed_out = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  always #2 clk = ~clk;

  taylor_sin_cos_evaluator DUT (.*);

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v, inout logic f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic trig_t taylor_predict(input logic signed [31:0] ang, input logic [3:0] tc);
    logic signed [63:0] two_pi, x, s, c, t, d;
    logic [63:0] ax, mag;
    logic f, xneg, neg;
    int n;
    trig_t r;
    two_pi = $signed(tsc_pkg::TWO_PI_Q64);
    n = (tc < 1) ? 1 : (tc > 10) ? 10 : tc;
    f = 1'b0;
    x = ang;
    if (x > two_pi || x < -two_pi) x = x - (x / two_pi) * two_pi;
    xneg = x < 0;
    ax = xneg ? -x : x;
    mag = 64'd1 << 24;
    s = 0;
    c = $signed(mag);
    for (int k = 1; k < 2 * n; k++) begin
      mag = ((mag * ax) >> 24) / k;
      if (mag > 64'd2147483647) begin
        mag = 64'd2147483647;
        f = 1'b1;
      end
      neg = (xneg && k[0]) != k[1];
      t = neg ? -$signed(mag) : $signed(mag);
      if (k[0]) s = sat32(s + t, f);
      else c = sat32(c + t, f);
    end
    d = sat32(s - c, f);
    r.sine = s[31:0];
    r.cosine = c[31:0];
    r.diff = d[31:0];
    r.sat = f;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        trig_q.push_back(taylor_predict(in_angle, terms_cur));
        void'(angle_q.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(1, 9);
        in_valid <= 1'b0;
      end else if (angle_q.size() != 0) begin
        in_valid <= 1'b1;
        in_angle <= angle_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (trig_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result beat, sine %h", out_sine_value);
        end else begin
          trig_t e;
          e = trig_q.pop_front();
          if (e.sine !== out_sine_value || e.cosine !== out_cosine_value ||
              e.diff !== out_sine_minus_cosine || e.sat !== out_saturated_flag) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %b got %h %h %h %b", e.sine, e.cosine, e.diff,
                       e.sat, out_sine_value, out_cosine_value, out_sine_minus_cosine,
                       out_saturated_flag);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while ((angle_q.size() != 0 || in_valid || trig_q.size() != 0) && !timed_out)
      @(posedge clk);
  endtask

  task automatic set_terms(input logic [3:0] v);
    repeat (QUIET_TAIL) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    terms_cur = v;
  endtask

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0c90fdaa)) - 32'sh06487ed5;
      2: return $signed($urandom_range(0, 32'h3243f6a9)) - 32'sh1921fb54;
      default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  initial begin
    logic [3:0] settings[6] = '{4'd10, 4'd0, 4'd1, 4'd15, 4'd5, 4'd3};
    fork
      begin
        wait (timed_out);
      end
      begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        foreach (settings[i]) begin
          if (i > 0) set_terms(settings[i]);
          if (i == 0) begin
            angle_q.push_back(32'sh7fffffff);
            angle_q.push_back(32'sh80000000);
            angle_q.push_back(32'sh00000000);
            angle_q.push_back(32'sh06487ed5);
            angle_q.push_back(32'sh06487ed6);
            angle_q.push_back(-32'sh06487ed5);
            angle_q.push_back(-32'sh06487ed6);
            angle_q.push_back(32'sh01921fb5);
            angle_q.push_back(32'sh03243f6a);
            angle_q.push_back(-32'sh03243f6a);
            angle_q.push_back(32'sh00000001);
            angle_q.push_back(32'shffffffff);
            angle_q.push_back(32'sh55555555);
            angle_q.push_back(32'shaaaaaaaa);
            drain();
          end
          if (i == 5) calm = 1'b1;
          repeat (N_RANDOM / 6) angle_q.push_back(rand_angle());
          if (i == 2) begin
            while (angle_q.size() > 150) @(posedge clk);
            drain();
            repeat (N_RANDOM / 30) angle_q.push_back(rand_angle());
          end
          drain();
        end
        repeat (QUIET_TAIL) @(posedge clk);
      end
    join_any
    $display("Checked %0d results over term counts 10, 0, 1, 15, 5 and 3.", results_seen);
    if (!timed_out && mismatches == 0 && trig_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d results still awaited", trig_q.size());
    end
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_ctrl.sv
rtl/tsc_dp.sv
rtl/taylor_sin_cos_evaluator.sv
sim/taylor_sin_cos_evaluator_tb.sv
